// File: rtl/core/mbf_pkg.sv
// Shared types and constants for the multi-filter Bloom set.
// Used by mbf_ctrl, mbf_dp and multi_bloom_filter_insert_query_top; no dependencies.
package mbf_pkg;

  localparam int NUM_FILTERS = 4;
  localparam int FILTER_BITS = 1024;
  localparam int INDEX_BITS  = 10;
  localparam int NUM_HASHES  = 4;
  localparam int HASH_W      = 40;
  localparam int FILL_W      = 11;
  localparam int FID_W       = 2;
  localparam int CNT_W       = 3;
  localparam int ADDR_W      = $clog2(FILTER_BITS);
  localparam int HK_W        = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [FILL_W-1:0] MAX_FILL_RST = FILL_W'(512);

  // Register index, taken from the word part of the APB address.
  localparam logic REG_MAX_FILL = 1'b0;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PICK,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } mbf_state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic pick;
    logic read;
    logic check;
    logic finish;
  } mbf_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic last_hash;
    logic dropped;
    logic out_free;
  } mbf_stat_t;

endpackage

// File: rtl/core/mbf_ctrl.sv
// Controller state machine for the multi-filter Bloom set.
// Depends on mbf_pkg; drives mbf_dp through command and status structs.
module mbf_ctrl
  import mbf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  mbf_stat_t stat,
  output mbf_cmd_t  cmd
);

  mbf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd.pick = 1'b1;
        // A dropped insert touches no filter bits.
        state_next = stat.dropped ? ST_DONE : ST_READ;
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.last_hash ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command at once");
  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.read |=> cmd.check)
    else $error("read not followed by check");
  a_stall_when_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.pick |-> in_stall)
    else $error("input open while an item is in progress");

endmodule

// File: rtl/core/mbf_dp.sv
// Datapath of the multi-filter Bloom set: bit store, fill counts and result register.
// Depends on mbf_pkg; sequenced by mbf_ctrl.
module mbf_dp
  import mbf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  mbf_cmd_t            cmd,
  output mbf_stat_t           stat,
  input  logic [FILL_W-1:0]   max_fill,
  input  logic                opcode,
  input  logic [HASH_W-1:0]   hash_bits,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                hit,
  output logic [FID_W-1:0]    filter_used,
  output logic                overflow,
  output logic [CNT_W-1:0]    filters_in_use
);

  // One row per bit index, one column per filter, so a row read serves all filters.
  logic [NUM_FILTERS-1:0] mem [FILTER_BITS];
  logic [NUM_FILTERS-1:0] rdata;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      clr_addr;

  logic                   op_q;
  logic [HASH_W-1:0]      hash_q;
  logic [HK_W-1:0]        hk;
  logic [FID_W-1:0]       tgt;
  logic                   drop;
  logic [NUM_FILTERS-1:0] acc;
  logic [FILL_W-1:0]      fill [NUM_FILTERS];
  logic [CNT_W-1:0]       open_cnt;

  logic [ADDR_W-1:0]      idx [NUM_HASHES];
  logic [ADDR_W-1:0]      cur_idx;
  logic [NUM_FILTERS-1:0] open_mask;
  logic [NUM_FILTERS-1:0] tgt_bit;
  logic                   found;
  logic [FID_W-1:0]       sel;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_wa;
  logic [NUM_FILTERS-1:0] mem_wd;

  // Indices are cut most significant first; each slice is as wide as an index, so no bits are dropped.
  always_comb begin
    for (int j = 0; j < NUM_HASHES; j++) begin
      idx[j] = hash_q[HASH_W-1-INDEX_BITS*j -: ADDR_W];
    end
  end

  assign cur_idx = idx[hk];
  assign tgt_bit = NUM_FILTERS'(1) << tgt;

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int f = NUM_FILTERS - 1; f >= 0; f--) begin
      open_mask[f] = CNT_W'(f) < open_cnt;
      if (open_mask[f] && (fill[f] < max_fill)) begin
        found = 1'b1;
        sel   = FID_W'(f);
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_addr;
    mem_wd = rdata | tgt_bit;
    if (cmd.clear_step) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else if (cmd.check && (op_q == OP_INSERT) && !rdata[tgt]) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.read) begin
      rdata <= mem[cur_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      open_cnt <= '0;
      for (int f = 0; f < NUM_FILTERS; f++) begin
        fill[f] <= '0;
      end
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.pick && (op_q == OP_INSERT) && !found && (open_cnt < CNT_W'(NUM_FILTERS))) begin
        open_cnt <= open_cnt + 1'b1;
      end
      if (cmd.check && (op_q == OP_INSERT) && !rdata[tgt]) begin
        fill[tgt] <= fill[tgt] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode;
      hash_q <= hash_bits;
    end
    if (cmd.pick) begin
      hk  <= '0;
      acc <= open_mask;
      if (found) begin
        tgt  <= sel;
        drop <= 1'b0;
      end else begin
        tgt  <= open_cnt[FID_W-1:0];
        drop <= (op_q == OP_INSERT) && (open_cnt >= CNT_W'(NUM_FILTERS));
      end
    end
    if (cmd.read) begin
      rd_addr <= cur_idx;
    end
    if (cmd.check) begin
      hk  <= hk + 1'b1;
      acc <= acc & rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit            <= (op_q == OP_QUERY) && (|acc);
      filter_used    <= ((op_q == OP_QUERY) || drop) ? '0 : tgt;
      overflow       <= (op_q == OP_INSERT) && drop;
      filters_in_use <= open_cnt;
    end
  end

  // The dropped flag is decided combinationally in the pick cycle for the controller.
  assign stat.dropped    = (op_q == OP_INSERT) && !found && (open_cnt >= CNT_W'(NUM_FILTERS));
  assign stat.clear_last = clr_addr == ADDR_W'(FILTER_BITS - 1);
  assign stat.last_hash  = hk == HK_W'(NUM_HASHES - 1);
  assign stat.out_free   = !out_valid || !out_stall;

  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    open_cnt <= CNT_W'(NUM_FILTERS))
    else $error("open filter count beyond filter count");
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (filters_in_use == CNT_W'(NUM_FILTERS)))
    else $error("overflow with a free filter left");
  a_hit_query: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (filter_used == '0) && !overflow)
    else $error("hit mixed with insert result");
  a_result_once: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished item not presented");

endmodule

// File: rtl/core/multi_bloom_filter_insert_query_top.sv
// An accepted item is loaded, a filter is picked, then each hash index is read and checked
// in turn before the result is registered; a dropped insert skips the reads and checks.
// The bit store does one read and one conditional write per hash; no new item is
// accepted until the last one has finished. Reset: synchronous; afterwards a clearing
// pass zeroes the bit store, one row per cycle, while input stays stalled; config is taken.
// Top level: APB register, controller and datapath; depends on mbf_pkg, mbf_ctrl, mbf_dp.
module multi_bloom_filter_insert_query_top
  import mbf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [HASH_W-1:0]  hash_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic [FID_W-1:0]   filter_used,
  output logic               overflow,
  output logic [CNT_W-1:0]   filters_in_use
);

  logic [FILL_W-1:0] max_fill;
  mbf_cmd_t          cmd;
  mbf_stat_t         stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_fill <= MAX_FILL_RST;
    end else if (psel && penable && pwrite && (paddr[APB_AW-1] == REG_MAX_FILL)) begin
      max_fill <= pwdata[FILL_W-1:0];
    end
  end

  assign prdata = (paddr[APB_AW-1] == REG_MAX_FILL) ? APB_DW'(max_fill) : '0;

  mbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mbf_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .max_fill       (max_fill),
    .opcode         (opcode),
    .hash_bits      (hash_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .filter_used    (filter_used),
    .overflow       (overflow),
    .filters_in_use (filters_in_use)
  );

endmodule
